FILE: sv/ppt_pkg.sv
// ppt_pkg: types, codes and fixed widths shared by the point in polygon test
// depends on nothing; used by ppt_ctrl, ppt_dp and point_in_polygon_test
package ppt_pkg;

	// coordinate and arithmetic widths
	localparam int COORD_BITS   = 16;
	localparam int DIFF_BITS    = COORD_BITS + 1;
	localparam int PROD_BITS    = 2 * DIFF_BITS;
	localparam int MIN_VERTICES = 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_TEST   = 2'd2
	} opcode_t;

	// input item
	typedef struct packed {
		opcode_t opcode;
		coord_t  coord_x;
		coord_t  coord_y;
		logic    last_point;
	} cmd_t;

	// result item
	typedef struct packed {
		logic inside_res;
		logic any_inside;
		logic run_done;
	} result_t;

	// stored vertex
	typedef struct packed {
		coord_t x;
		coord_t y;
	} vertex_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_REPORT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clear_cnt;
		logic append;
		logic load_point;
		logic rd_issue;
		logic report;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic small_poly;
		logic rd_last;
		logic pipe_empty;
	} dp_status_t;

endpackage

FILE: sv/ppt_ram.sv
// ppt_ram: generic single write port, single read port RAM with registered read
// depends on nothing
module ppt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/ppt_ctrl.sv
// ppt_ctrl: state machine that decodes items and sequences the edge walk
// depends on ppt_pkg
module ppt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ppt_pkg::opcode_t    opcode,
	input  ppt_pkg::dp_status_t status,
	output logic                busy,
	output ppt_pkg::ctrl_cmd_t  ctrl
);

	ppt_pkg::state_t state_q, state_d;
	logic            accept;

	assign accept = start && !busy;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ppt_pkg::ST_IDLE: begin
				if (accept && opcode == ppt_pkg::OP_TEST) begin
					state_d = status.small_poly ? ppt_pkg::ST_REPORT : ppt_pkg::ST_READ;
				end
			end
			ppt_pkg::ST_READ: begin
				if (status.rd_last) begin
					state_d = ppt_pkg::ST_DRAIN;
				end
			end
			ppt_pkg::ST_DRAIN: begin
				if (status.pipe_empty) begin
					state_d = ppt_pkg::ST_REPORT;
				end
			end
			ppt_pkg::ST_REPORT: begin
				state_d = ppt_pkg::ST_IDLE;
			end
			default: begin
				state_d = ppt_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		ctrl = '0;
		busy = (state_q != ppt_pkg::ST_IDLE);
		unique case (state_q)
			ppt_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (opcode)
						ppt_pkg::OP_CLEAR:  ctrl.clear_cnt  = 1'b1;
						ppt_pkg::OP_APPEND: ctrl.append     = 1'b1;
						ppt_pkg::OP_TEST:   ctrl.load_point = 1'b1;
						default: ;
					endcase
				end
			end
			ppt_pkg::ST_READ:   ctrl.rd_issue = 1'b1;
			ppt_pkg::ST_DRAIN:  ;
			ppt_pkg::ST_REPORT: ctrl.report   = 1'b1;
			default: ;
		endcase
	end

endmodule

FILE: sv/ppt_dp.sv
// ppt_dp: vertex store, edge former, crossing pipeline and result register
// depends on ppt_pkg and ppt_ram
module ppt_dp #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ppt_pkg::cmd_t       cmd,
	input  ppt_pkg::ctrl_cmd_t  ctrl,
	output ppt_pkg::dp_status_t status,
	output logic                result_valid,
	output ppt_pkg::result_t    result
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	logic [CW-1:0]     count_q;
	logic [AW-1:0]     rd_addr_q;
	logic              wr_en;
	ppt_pkg::vertex_t  wr_vtx;
	ppt_pkg::vertex_t  rd_vtx;
	ppt_pkg::coord_t   px_q, py_q;
	logic              last_q;
	logic              run_hit_q;
	logic              parity_q;

	// read tags
	logic              rd_vld_s1, rd_first_s1, rd_last_s1;

	// edge former
	ppt_pkg::vertex_t  v0_q, prev_q;
	logic              wrap_pend_q;
	ppt_pkg::vertex_t  ea_s2, eb_s2;
	logic              e_vld_s2;

	// ordering and differences
	ppt_pkg::vertex_t  lo_v, up_v;
	logic              ok_s3, vld_s3;
	ppt_pkg::diff_t    dyp_s3, dxu_s3, dxp_s3, dyu_s3;

	// products
	ppt_pkg::prod_t    lhs_s4, rhs_s4;
	logic              ok_s4, vld_s4;

	logic              hit, any_hit;

	// vertex count and append
	assign wr_en  = ctrl.append && (count_q != CW'(MAX_VERTICES));
	assign wr_vtx = '{x: cmd.coord_x, y: cmd.coord_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.clear_cnt) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + CW'(1);
		end
	end

	ppt_ram #(
		.WIDTH ($bits(ppt_pkg::vertex_t)),
		.DEPTH (MAX_VERTICES)
	) u_vtx_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AW-1:0]),
		.wdata (wr_vtx),
		.re    (ctrl.rd_issue),
		.raddr (rd_addr_q),
		.rdata (rd_vtx)
	);

	// test point capture
	always_ff @(posedge clk) begin
		if (ctrl.load_point) begin
			px_q   <= cmd.coord_x;
			py_q   <= cmd.coord_y;
			last_q <= cmd.last_point;
		end
	end

	// read address walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q   <= '0;
			rd_vld_s1   <= 1'b0;
			rd_first_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
		end else begin
			rd_vld_s1   <= ctrl.rd_issue;
			rd_first_s1 <= ctrl.rd_issue && (rd_addr_q == '0);
			rd_last_s1  <= ctrl.rd_issue && status.rd_last;
			if (ctrl.load_point) begin
				rd_addr_q <= '0;
			end else if (ctrl.rd_issue) begin
				rd_addr_q <= rd_addr_q + AW'(1);
			end
		end
	end

	// edge former: pairs each vertex with the one before, then the closing edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_vld_s2    <= 1'b0;
			wrap_pend_q <= 1'b0;
		end else begin
			e_vld_s2 <= 1'b0;
			if (rd_vld_s1) begin
				e_vld_s2    <= !rd_first_s1;
				wrap_pend_q <= rd_last_s1;
			end else if (wrap_pend_q) begin
				e_vld_s2    <= 1'b1;
				wrap_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (rd_first_s1) begin
				v0_q <= rd_vtx;
			end
			prev_q <= rd_vtx;
			ea_s2  <= prev_q;
			eb_s2  <= rd_vtx;
		end else if (wrap_pend_q) begin
			ea_s2 <= prev_q;
			eb_s2 <= v0_q;
		end
	end

	// order ends by y, range test and differences
	always_comb begin
		if (ea_s2.y > eb_s2.y) begin
			lo_v = eb_s2;
			up_v = ea_s2;
		end else begin
			lo_v = ea_s2;
			up_v = eb_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= e_vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ok_s3  <= (py_q >= lo_v.y) && (py_q <= up_v.y) && (up_v.y != lo_v.y);
		dyp_s3 <= ppt_pkg::DIFF_BITS'(py_q) - ppt_pkg::DIFF_BITS'(lo_v.y);
		dxu_s3 <= ppt_pkg::DIFF_BITS'(up_v.x) - ppt_pkg::DIFF_BITS'(lo_v.x);
		dxp_s3 <= ppt_pkg::DIFF_BITS'(px_q) - ppt_pkg::DIFF_BITS'(lo_v.x);
		dyu_s3 <= ppt_pkg::DIFF_BITS'(up_v.y) - ppt_pkg::DIFF_BITS'(lo_v.y);
	end

	// cross products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		ok_s4  <= ok_s3;
		lhs_s4 <= dyp_s3 * dxu_s3;
		rhs_s4 <= dxp_s3 * dyu_s3;
	end

	// crossing parity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
		end else if (ctrl.load_point) begin
			parity_q <= 1'b0;
		end else if (vld_s4 && ok_s4 && (lhs_s4 > rhs_s4)) begin
			parity_q <= !parity_q;
		end
	end

	// result and run flag
	assign hit     = parity_q;
	assign any_hit = run_hit_q || hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_hit_q    <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= ctrl.report;
			if (ctrl.report) begin
				run_hit_q <= last_q ? 1'b0 : any_hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.report) begin
			result.inside_res <= hit;
			result.any_inside <= any_hit;
			result.run_done   <= last_q;
		end
	end

	// status to controller
	assign status.small_poly = (count_q < CW'(ppt_pkg::MIN_VERTICES));
	assign status.rd_last    = (CW'(rd_addr_q) == (count_q - CW'(1)));
	assign status.pipe_empty = !(rd_vld_s1 || wrap_pend_q || e_vld_s2 || vld_s3 || vld_s4);

endmodule

FILE: sv/point_in_polygon_test.sv
// point_in_polygon_test: even-odd ray crossing test against a stored polygon
// depends on ppt_pkg, ppt_ctrl, ppt_dp and ppt_ram
//
// channel  direction  handshake               payload
// input    in         start high, busy low    cmd    (ppt_pkg::cmd_t)
// result   out        result_valid, 1 cycle   result (ppt_pkg::result_t)
//
// busy stays low for clear and append, so they may follow back to back
// a test walks the vertex RAM one edge per cycle through its single read port
// with fewer than three stored vertices a test skips the walk and reports directly
// asynchronous active-low reset empties the polygon and the run flag; RAM is not cleared
// the receiver cannot stall: each result is shown for exactly one cycle
module point_in_polygon_test #(
	parameter int MAX_VERTICES = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ppt_pkg::cmd_t    cmd,
	output logic             result_valid,
	output ppt_pkg::result_t result
);

	ppt_pkg::ctrl_cmd_t  ctrl;
	ppt_pkg::dp_status_t status;

	ppt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (cmd.opcode),
		.status (status),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	ppt_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.ctrl         (ctrl),
		.status       (status),
		.result_valid (result_valid),
		.result       (result)
	);

	// a result only appears once the walk has finished
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result shown while a test is still running");

	// one result per test, never two in a row
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held for more than one cycle");

	// run flag must cover the current point
	a_any_covers: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.inside_res) |-> result.any_inside)
		else $error("inside point not reflected in run flag");

	// the walk never starts without a test transfer
	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ctrl.rd_issue) |-> $past(ctrl.load_point))
		else $error("edge walk started without a test transfer");

endmodule
